[rtl/core/kfh_pkg.sv]
// ----------------------------------------------------------------------------
// kfh_pkg - keyframe Hermite interpolator shared definitions
// Widths, codes, sequencer states and helpers shared by the interpolator files.
// ----------------------------------------------------------------------------
package kfh_pkg;

   localparam int MAX_KEYS_DEF = 64;
   localparam int KEY_W        = 32;   // Q16.16 time and value
   localparam int SLOT_W       = 6;
   localparam int CFG_W        = 7;
   localparam int FRAC_W       = 16;
   localparam int ACC_W        = 40;   // Horner accumulator
   localparam int TFR_W        = FRAC_W + 1;
   localparam int PROD_W       = ACC_W + TFR_W;
   localparam int DIV_STEPS    = FRAC_W + 1;
   localparam int DIV_CNT_W    = $clog2(DIV_STEPS);
   localparam int REQ_TDATA_W  = 104;
   localparam int RSP_TDATA_W  = 32;
   localparam int KIND_W       = 2;

   localparam logic signed [ACC_W-1:0] ONE_Q   = ACC_W'(65536);
   localparam logic signed [PROD_W-1:0] HALF_Q = PROD_W'(32768);

   // request type
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // result kind
   localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_INTERP = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FIRST  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_LAST   = 2'd3;

   // Horner step addends
   localparam logic [1:0] POLY_C2  = 2'd0;
   localparam logic [1:0] POLY_ONE = 2'd1;
   localparam logic [1:0] POLY_V0  = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RD_FIRST,
      S_CHK_FIRST,
      S_CHK_LAST,
      S_SEARCH,
      S_DIV_SETUP,
      S_DIV,
      S_POLY_LOAD,
      S_POLY_MUL,
      S_POLY_RND,
      S_DONE
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   function automatic logic signed [KEY_W-1:0] sat_key(input logic signed [ACC_W-1:0] x);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = ACC_W'(64'sh7FFF_FFFF);
      lo = -ACC_W'(64'sh8000_0000);
      if (x > hi) begin
         return KEY_W'(hi);
      end else if (x < lo) begin
         return KEY_W'(lo);
      end
      return x[KEY_W-1:0];
   endfunction

endpackage

[rtl/core/kfh_div.sv]
// ----------------------------------------------------------------------------
// kfh_div - fraction divider
// Restoring divider, one quotient bit per cycle: quot = floor(num * 2^16 / den)
// for 0 < num <= den, so the quotient fits in 17 bits.
// ----------------------------------------------------------------------------
module kfh_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [kfh_pkg::KEY_W-1:0]     num,
   input  logic [kfh_pkg::KEY_W-1:0]     den,
   output logic [kfh_pkg::TFR_W-1:0]     quot,
   output kfh_pkg::div_stat_type         stat
);

   logic [kfh_pkg::KEY_W:0]           rem_ff, rem_in;
   logic [kfh_pkg::KEY_W-1:0]         den_ff;
   logic [kfh_pkg::TFR_W-1:0]         quot_ff, quot_in;
   logic [kfh_pkg::DIV_CNT_W-1:0]     cnt_ff;
   logic                              busy_ff, done_ff;
   logic                              ge;
   logic [kfh_pkg::KEY_W:0]           diff;

   always_comb begin
      ge      = rem_ff >= {1'b0, den_ff};
      diff    = rem_ff - {1'b0, den_ff};
      // remainder stays below den, so doubling fits in KEY_W+1 bits
      rem_in  = ge ? {diff[kfh_pkg::KEY_W-1:0], 1'b0} : {rem_ff[kfh_pkg::KEY_W-1:0], 1'b0};
      quot_in = {quot_ff[kfh_pkg::TFR_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == kfh_pkg::DIV_CNT_W'(kfh_pkg::DIV_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= {1'b0, num};
         den_ff  <= den;
         quot_ff <= '0;
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         quot_ff <= quot_in;
      end
   end

   assign quot      = quot_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

[rtl/core/keyframe_hermite_interpolator_unit.sv]
// ----------------------------------------------------------------------------
// keyframe_hermite_interpolator_unit - keyframe table with Hermite evaluation
// Holds MAX_KEYS keyframes, answers key writes and curve queries.
//
//   channel | ports            | direction | word
//   --------+------------------+-----------+-----------------------------------
//   req     | req_t*           | in        | key write or curve query
//   rsp     | rsp_t*           | out       | curve value and result kind
//   csr     | csr_*            | in        | keys_in_use
//
// From the accepting edge to rsp_tvalid: a key write goes straight to the
// result; a query reads the first key and clamps to it, then the last key
// and clamps to it, else runs a linear key search (one memory read a cycle),
// the divider setup and the 17 quotient bits (skipped when t is forced to zero),
// three Horner steps on the shared multiplier and the result load. Reset is
// synchronous; the key table is not cleared. req_tready rises again in idle.
// The result register frees the sequencer; a stalled rsp holds only the
// finishing step of the next item.
// ----------------------------------------------------------------------------
module keyframe_hermite_interpolator_unit #(
   parameter int MAX_KEYS = kfh_pkg::MAX_KEYS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // key_slot[5:0], key_time[37:6], key_value[69:38], query_time[101:70]
   input  logic [kfh_pkg::REQ_TDATA_W-1:0]      req_tdata,
   // req_type[0]
   input  logic                                 req_tuser,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // curve_value[31:0]
   output logic [kfh_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   // result_kind[1:0]
   output logic [kfh_pkg::KIND_W-1:0]           rsp_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic [kfh_pkg::CFG_W-1:0]            csr_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready
);

   localparam int IDX_W = $clog2(MAX_KEYS);
   localparam int CMP_W = ($clog2(MAX_KEYS + 1) > kfh_pkg::CFG_W) ?
                          $clog2(MAX_KEYS + 1) : kfh_pkg::CFG_W;
   localparam int KW    = kfh_pkg::KEY_W;

   // key table
   logic [KW-1:0] key_times  [MAX_KEYS];
   logic [KW-1:0] key_values [MAX_KEYS];
   logic signed [KW-1:0] tdat_ff, vdat_ff;
   logic [IDX_W-1:0]     rd_addr;

   kfh_pkg::state_type state_ff, state_in;

   logic [kfh_pkg::CFG_W-1:0]           keys_ff;
   logic signed [KW-1:0]                q_ff, tprev_ff, vprev_ff;
   logic [IDX_W-1:0]                    idx_ff, nlast;
   logic signed [KW:0]                  num_ff, den_ff, d_ff;
   logic signed [KW:0]                  num_in, den_in, d_in;
   logic [kfh_pkg::FRAC_W-1:0]          t_ff;
   logic signed [kfh_pkg::ACC_W-1:0]    acc_ff, acc_in, addend, d_ext, v0_ext;
   logic signed [kfh_pkg::PROD_W-1:0]   prod_ff, rnd_full;
   logic [1:0]                          step_ff;
   logic signed [KW-1:0]                res_val_ff;
   logic [kfh_pkg::KIND_W-1:0]          res_kind_ff;
   logic                                rsp_valid_ff;

   logic req_acc, out_free, out_load, div_start, wr_en;
   logic [CMP_W-1:0] keys_ext, slot_ext;
   logic [IDX_W-1:0] wr_addr;
   logic signed [KW-1:0] f_time, f_value, f_query;
   logic [kfh_pkg::SLOT_W-1:0] f_slot;
   logic search_lt, search_go, div_skip;
   logic [kfh_pkg::TFR_W-1:0] quot;
   kfh_pkg::div_stat_type div_stat;

   assign f_slot  = req_tdata[5:0];
   assign f_time  = req_tdata[37:6];
   assign f_value = req_tdata[69:38];
   assign f_query = req_tdata[101:70];

   assign req_acc  = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign csr_ready = 1'b1;

   // effective last key index: zero acts as one, large counts clamp
   always_comb begin
      keys_ext = CMP_W'(keys_ff);
      if (keys_ext == '0) begin
         nlast = '0;
      end else if (keys_ext > CMP_W'(MAX_KEYS)) begin
         nlast = IDX_W'(MAX_KEYS - 1);
      end else begin
         nlast = IDX_W'(keys_ext - 1'b1);
      end
   end

   assign slot_ext = CMP_W'(f_slot);
   assign wr_addr  = IDX_W'(slot_ext);
   assign wr_en    = req_acc && (req_tuser == kfh_pkg::REQ_WRITE) &&
                     (slot_ext < CMP_W'(MAX_KEYS));

   assign search_lt = tdat_ff < q_ff;
   assign search_go = search_lt && (idx_ff != nlast);
   assign num_in    = (KW+1)'(q_ff) - (KW+1)'(tprev_ff);
   assign den_in    = (KW+1)'(tdat_ff) - (KW+1)'(tprev_ff);
   assign d_in      = (KW+1)'(vdat_ff) - (KW+1)'(vprev_ff);
   assign div_skip  = num_ff[KW] || (num_ff == '0) || den_ff[KW] || (den_ff == '0);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         kfh_pkg::S_IDLE: begin
            if (req_acc) begin
               state_in = (req_tuser == kfh_pkg::REQ_QUERY) ? kfh_pkg::S_RD_FIRST
                                                            : kfh_pkg::S_DONE;
            end
         end
         kfh_pkg::S_RD_FIRST:  state_in = kfh_pkg::S_CHK_FIRST;
         kfh_pkg::S_CHK_FIRST: state_in = (q_ff <= tdat_ff) ? kfh_pkg::S_DONE
                                                            : kfh_pkg::S_CHK_LAST;
         kfh_pkg::S_CHK_LAST:  state_in = (q_ff >= tdat_ff) ? kfh_pkg::S_DONE
                                                            : kfh_pkg::S_SEARCH;
         kfh_pkg::S_SEARCH:    state_in = search_go ? kfh_pkg::S_SEARCH
                                                    : kfh_pkg::S_DIV_SETUP;
         kfh_pkg::S_DIV_SETUP: state_in = div_skip ? kfh_pkg::S_POLY_LOAD : kfh_pkg::S_DIV;
         kfh_pkg::S_DIV:       state_in = div_stat.done ? kfh_pkg::S_POLY_LOAD
                                                        : kfh_pkg::S_DIV;
         kfh_pkg::S_POLY_LOAD: state_in = kfh_pkg::S_POLY_MUL;
         kfh_pkg::S_POLY_MUL:  state_in = kfh_pkg::S_POLY_RND;
         kfh_pkg::S_POLY_RND:  state_in = (step_ff == kfh_pkg::POLY_V0) ? kfh_pkg::S_DONE
                                                                      : kfh_pkg::S_POLY_MUL;
         kfh_pkg::S_DONE:      state_in = out_free ? kfh_pkg::S_IDLE : kfh_pkg::S_DONE;
         default:              state_in = kfh_pkg::S_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready = 1'b0;
      div_start  = 1'b0;
      out_load   = 1'b0;
      rd_addr    = '0;
      unique case (state_ff)
         kfh_pkg::S_IDLE:      req_tready = 1'b1;
         kfh_pkg::S_CHK_FIRST: rd_addr = nlast;
         kfh_pkg::S_CHK_LAST:  rd_addr = IDX_W'(1);
         kfh_pkg::S_SEARCH:    rd_addr = idx_ff + IDX_W'(1);
         kfh_pkg::S_DIV_SETUP: div_start = !div_skip;
         kfh_pkg::S_DONE:      out_load = out_free;
         default:              rd_addr = '0;
      endcase
   end

   // table memory: one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_times[wr_addr]  <= f_time;
         key_values[wr_addr] <= f_value;
      end
      tdat_ff <= key_times[rd_addr];
      vdat_ff <= key_values[rd_addr];
   end

   kfh_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_ff[KW-1:0]),
      .den   (den_ff[KW-1:0]),
      .quot  (quot),
      .stat  (div_stat)
   );

   // Horner step: acc = R(acc * t) + addend
   assign d_ext    = kfh_pkg::ACC_W'(d_ff);
   assign v0_ext   = kfh_pkg::ACC_W'(vprev_ff);
   assign rnd_full = (prod_ff + kfh_pkg::HALF_Q) >>> kfh_pkg::FRAC_W;

   always_comb begin
      case (step_ff)
         kfh_pkg::POLY_C2:  addend = (d_ext <<< 1) + d_ext - kfh_pkg::ONE_Q;
         kfh_pkg::POLY_ONE: addend = kfh_pkg::ONE_Q;
         kfh_pkg::POLY_V0:  addend = v0_ext;
         default:           addend = '0;
      endcase
      acc_in = rnd_full[kfh_pkg::ACC_W-1:0] + addend;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kfh_pkg::S_IDLE;
         keys_ff      <= kfh_pkg::CFG_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            keys_ff <= csr_data;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         kfh_pkg::S_IDLE: begin
            q_ff        <= f_query;
            res_val_ff  <= '0;
            res_kind_ff <= kfh_pkg::KIND_WRITE;
         end
         kfh_pkg::S_CHK_FIRST: begin
            tprev_ff    <= tdat_ff;
            vprev_ff    <= vdat_ff;
            res_val_ff  <= vdat_ff;
            res_kind_ff <= kfh_pkg::KIND_FIRST;
         end
         kfh_pkg::S_CHK_LAST: begin
            idx_ff      <= IDX_W'(1);
            res_val_ff  <= vdat_ff;
            res_kind_ff <= kfh_pkg::KIND_LAST;
         end
         kfh_pkg::S_SEARCH: begin
            if (search_go) begin
               tprev_ff <= tdat_ff;
               vprev_ff <= vdat_ff;
               idx_ff   <= idx_ff + IDX_W'(1);
            end else begin
               num_ff <= num_in;
               den_ff <= den_in;
               d_ff   <= d_in;
            end
         end
         kfh_pkg::S_DIV_SETUP: begin
            t_ff <= '0;
         end
         kfh_pkg::S_DIV: begin
            // a fraction reaching 1.0 holds at the largest code
            if (div_stat.done) begin
               t_ff <= quot[kfh_pkg::FRAC_W] ? '1 : quot[kfh_pkg::FRAC_W-1:0];
            end
         end
         kfh_pkg::S_POLY_LOAD: begin
            acc_ff  <= -(d_ext <<< 1);
            step_ff <= kfh_pkg::POLY_C2;
         end
         kfh_pkg::S_POLY_MUL: begin
            prod_ff <= acc_ff * $signed({1'b0, t_ff});
         end
         kfh_pkg::S_POLY_RND: begin
            acc_ff  <= acc_in;
            step_ff <= step_ff + 2'd1;
            if (step_ff == kfh_pkg::POLY_V0) begin
               res_val_ff  <= kfh_pkg::sat_key(acc_in);
               res_kind_ff <= kfh_pkg::KIND_INTERP;
            end
         end
         kfh_pkg::S_DONE: begin
            if (out_load) begin
               rsp_tdata <= res_val_ff;
               rsp_tuser <= res_kind_ff;
            end
         end
         default: begin
            t_ff <= t_ff;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

   // an accepted word always leaves idle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> state_ff != kfh_pkg::S_IDLE)
      else $error("sequencer stayed idle after accepting a word");

   // write acknowledgements carry a zero value
   a_write_ack_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == kfh_pkg::KIND_WRITE |-> rsp_tdata == '0)
      else $error("write acknowledgement with nonzero value");

   // divider finishes only while the sequencer waits for it
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> state_ff == kfh_pkg::S_DIV)
      else $error("divider finished outside its wait state");

   // key search never runs past the last key in use
   a_search_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == kfh_pkg::S_SEARCH |-> idx_ff <= nlast)
      else $error("key search index past last key");

   // a new result is loaded only when the output register is free
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> !rsp_valid_ff || rsp_tready)
      else $error("result register overwritten");

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench - keyframe Hermite interpolator unit
// Fills the keyframe table over the req stream, sets keys_in_use over the csr
// channel and checks every rsp word against a cycle-free model of the key
// search, the Q0.16 fraction and the rounded Horner evaluation.
// ----------------------------------------------------------------------------
module testbench;

   localparam int  KEY_W       = kfh_pkg::KEY_W;
   localparam int  SLOT_W      = kfh_pkg::SLOT_W;
   localparam int  CFG_W       = kfh_pkg::CFG_W;
   localparam int  KIND_W      = kfh_pkg::KIND_W;
   localparam int  REQ_TDATA_W = kfh_pkg::REQ_TDATA_W;
   localparam int  RSP_TDATA_W = kfh_pkg::RSP_TDATA_W;
   localparam int  KEYS        = kfh_pkg::MAX_KEYS_DEF;
   localparam int  CYCLE_LIMIT = 3_000_000;
   localparam int  ITEMS_PER_MODE = 530;
   localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;

   typedef struct {
      logic [RSP_TDATA_W-1:0] curve;
      logic [KIND_W-1:0]      kind;
   } curve_point_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic [REQ_TDATA_W-1:0]  req_tdata = '0;
   logic                    req_tuser = kfh_pkg::REQ_WRITE;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;
   logic [KIND_W-1:0]       rsp_tuser;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [CFG_W-1:0]        csr_data = '0;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;

   // model state: key table and key count as the block should hold them
   longint          key_time_tbl[KEYS];
   longint          key_value_tbl[KEYS];
   logic [CFG_W-1:0] key_count = 7'd1;

   curve_point_type pending_points[$];
   int              error_count = 0;
   int              items_sent = 0;
   int              cycle_count = 0;
   int              send_idle_pct = 0;
   int              recv_idle_pct = 0;

   keyframe_hermite_interpolator_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_data   (csr_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   function automatic int active_key_count(input logic [CFG_W-1:0] cfg);
      if (cfg == 0) return 1;
      if (cfg > KEYS) return KEYS;
      return int'(cfg);
   endfunction

   function automatic logic [KEY_W-1:0] saturate_q16(input longint x);
      if (x > longint'(KEY_MAX)) return KEY_MAX;
      if (x < longint'(KEY_MIN)) return KEY_MIN;
      return x[KEY_W-1:0];
   endfunction

   // expected rsp word for a query at qtime
   function automatic curve_point_type eval_curve(input logic signed [KEY_W-1:0] qtime);
      int                n;
      int                idx;
      longint            q, num, den, t, d, c2, c3, a, b, c, v0;
      longint unsigned   frac;
      curve_point_type   pt;
      n = active_key_count(key_count);
      q = longint'(qtime);
      if (q <= key_time_tbl[0]) begin
         pt.curve = saturate_q16(key_value_tbl[0]);
         pt.kind  = kfh_pkg::KIND_FIRST;
         return pt;
      end
      if (q >= key_time_tbl[n-1]) begin
         pt.curve = saturate_q16(key_value_tbl[n-1]);
         pt.kind  = kfh_pkg::KIND_LAST;
         return pt;
      end
      idx = 1;
      while (idx < n && key_time_tbl[idx] < q) idx++;
      if (idx >= n) idx = n - 1;
      num = q - key_time_tbl[idx-1];
      den = key_time_tbl[idx] - key_time_tbl[idx-1];
      if (den <= 0 || num <= 0) begin
         t = 0;
      end else begin
         frac = (longint'(num) << 16) / den;
         t = (frac > 65535) ? 65535 : longint'(frac);
      end
      v0 = key_value_tbl[idx-1];
      d  = key_value_tbl[idx] - v0;
      c3 = -2 * d;
      c2 = 3 * d - 65536;
      // Horner steps, each rounded half up (arithmetic shift is a floor)
      a = (c3 * t + 32768) >>> 16;
      b = ((a + c2) * t + 32768) >>> 16;
      c = ((b + 65536) * t + 32768) >>> 16;
      pt.curve = saturate_q16(v0 + c);
      pt.kind  = kfh_pkg::KIND_INTERP;
      return pt;
   endfunction

   // rsp checker
   always @(posedge clock) begin
      curve_point_type exp_pt;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_points.size() == 0) begin
            $error("unexpected rsp word: curve_value %h result_kind %0d",
                   rsp_tdata, rsp_tuser);
            error_count++;
         end else begin
            exp_pt = pending_points.pop_front();
            if (rsp_tdata !== exp_pt.curve) begin
               $error("curve_value: expected %h, got %h", exp_pt.curve, rsp_tdata);
               error_count++;
            end
            if (rsp_tuser !== exp_pt.kind) begin
               $error("result_kind: expected %0d, got %0d", exp_pt.kind, rsp_tuser);
               error_count++;
            end
         end
      end
   end

   // sends one req word; returns right after the accepting edge
   task automatic send_word(input logic rtype, input logic [SLOT_W-1:0] slot,
                            input logic signed [KEY_W-1:0] ktime,
                            input logic signed [KEY_W-1:0] kvalue,
                            input logic signed [KEY_W-1:0] qtime);
      curve_point_type pt;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= rtype;
      req_tdata  <= {2'b00, qtime, kvalue, ktime, slot};
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (rtype == kfh_pkg::REQ_WRITE) begin
         key_time_tbl[slot]  = longint'(ktime);
         key_value_tbl[slot] = longint'(kvalue);
         pt.curve = '0;
         pt.kind  = kfh_pkg::KIND_WRITE;
      end else begin
         pt = eval_curve(qtime);
      end
      pending_points.push_back(pt);
   endtask

   task automatic write_key(input int slot, input logic signed [KEY_W-1:0] ktime,
                            input logic signed [KEY_W-1:0] kvalue);
      send_word(kfh_pkg::REQ_WRITE, slot[SLOT_W-1:0], ktime, kvalue, $urandom);
   endtask

   task automatic query_curve(input logic signed [KEY_W-1:0] qtime);
      send_word(kfh_pkg::REQ_QUERY, SLOT_W'($urandom), $urandom, $urandom, qtime);
   endtask

   // drop valid and wait until every rsp word has come back
   task automatic drain;
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_points.size() != 0) @(negedge clock);
   endtask

   task automatic set_key_count(input int cfg);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= cfg[CFG_W-1:0];
      do @(posedge clock); while (!csr_ready);
      key_count = cfg[CFG_W-1:0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // one key in use: everything clamps to the first or last key
   task automatic test_single_key;
      write_key(0, 32'sh0001_0000, KEY_MAX);
      query_curve(32'sh0001_0000);
      query_curve(32'sh0000_FFFF);
      query_curve(32'sh0001_0001);
      query_curve(KEY_MIN);
      query_curve(KEY_MAX);
   endtask

   // zero keys in use acts as one
   task automatic test_key_count_zero;
      write_key(63, -1, KEY_MIN);
      set_key_count(0);
      query_curve(KEY_MAX);
      query_curve(32'sh0000_0000);
   endtask

   task automatic test_segments;
      write_key(0, KEY_MIN, KEY_MAX);
      write_key(1, 32'sh0000_0000, KEY_MIN);
      write_key(2, 32'sh0001_0000, KEY_MAX);
      write_key(3, KEY_MAX, KEY_MAX);
      set_key_count(4);
      query_curve(KEY_MIN + 1);          // widest interval, t near zero
      query_curve(32'sh0000_0000);       // exactly on a key: fraction held below 1.0
      query_curve(32'sh0000_8000);
      query_curve(32'sh0000_C000);
      query_curve(32'sh4000_0000);       // flat segment at the top: saturates
      query_curve(KEY_MAX - 1);
      query_curve(KEY_MAX);
      write_key(2, -100, 32'sh0000_0000); // keys no longer ascend
      query_curve(32'sh0000_0032);
   endtask

   function automatic logic signed [KEY_W-1:0] random_value();
      if ($urandom_range(99) < 30) return $urandom;
      return $signed(32'($urandom_range(32'h0040_0000))) - 32'sh0020_0000;
   endfunction

   function automatic logic signed [KEY_W-1:0] rand_between(input longint lo,
                                                             input longint hi);
      longint unsigned span;
      longint unsigned r;
      if (hi <= lo) return hi[KEY_W-1:0];
      span = hi - lo + 1;
      r    = {$urandom, $urandom};
      return KEY_W'(lo + longint'(r % span));
   endfunction

   // rebuild a non-descending table, pick a key count, then query it
   task automatic random_round(input bit force_top);
      int     cfg, n, nq, sel, k;
      longint cur;
      sel = $urandom_range(99);
      if (force_top) cfg = 127;
      else if (sel < 4) cfg = KEYS;
      else if (sel < 8) cfg = $urandom_range(KEYS + 1, 127);
      else if (sel < 12) cfg = $urandom_range(0, 1);
      else cfg = $urandom_range(2, 12);
      n = active_key_count(cfg[CFG_W-1:0]);
      sel = $urandom_range(3);
      if (sel == 0) cur = longint'(KEY_MIN) + $urandom_range(255);
      else if (sel == 1) cur = $signed($urandom);
      else cur = $signed(32'($urandom_range(32'h0010_0000))) - 32'sh0008_0000;
      for (int i = 0; i < n; i++) begin
         write_key(i, cur[KEY_W-1:0], random_value());
         cur += $urandom_range(0, 1 << $urandom_range(1, 24));
         if (cur > longint'(KEY_MAX)) cur = KEY_MAX;
      end
      set_key_count(cfg);
      nq = $urandom_range(15, 40);
      repeat (nq) begin
         sel = $urandom_range(99);
         if (sel < 68 && n >= 2) begin
            k = $urandom_range(1, n - 1);
            query_curve(rand_between(key_time_tbl[k-1], key_time_tbl[k]));
         end else if (sel < 78) begin
            query_curve(KEY_W'(key_time_tbl[$urandom_range(n - 1)]));
         end else if (sel < 86) begin
            query_curve($urandom);
         end else if (sel < 92) begin
            write_key($urandom_range(KEYS - 1), $urandom, random_value());
         end else if (sel < 96) begin
            query_curve(rand_between(longint'(KEY_MIN), key_time_tbl[0]));
         end else begin
            query_curve(rand_between(key_time_tbl[n-1], longint'(KEY_MAX)));
         end
      end
   endtask

   task automatic test_random_curves(input int send_pct, input int recv_pct,
                                     input int item_goal);
      bit first;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      first = 1'b1;
      while (items_sent < item_goal) begin
         random_round(first);
         first = 1'b0;
      end
   endtask

   initial begin
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      send_idle_pct = 17;
      recv_idle_pct = 76;
      test_single_key();
      test_key_count_zero();
      test_segments();
      test_random_curves(17, 76, items_sent + ITEMS_PER_MODE);
      test_random_curves(76, 17, items_sent + ITEMS_PER_MODE);
      test_random_curves(0, 0, items_sent + ITEMS_PER_MODE);
      drain();
      repeat (120) @(negedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
